@@ design/aksc_pkg.sv @@
`default_nettype none

package aksc_pkg;

    localparam int SLOTS    = 64;
    localparam int FRAMES   = 2;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FRAME_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int ENTRIES  = SLOTS * FRAMES;
    localparam int ENT_W    = $clog2(ENTRIES);
    localparam int KEY_W    = 64;
    localparam int AGE_W    = 5;
    localparam int MAXAGE_W = 4;
    localparam int OUT_SLOT_W = 6;

    localparam logic [AGE_W-1:0]    AGE_LIMIT     = 5'd31;
    localparam logic [MAXAGE_W-1:0] MAX_AGE_RESET = 4'd8;

    // request kind on s_tuser
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef enum logic [1:0] {
        STAT_HIT   = 2'd0,
        STAT_ALLOC = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_TICK  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_LAST = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    // first memory entry of a frame's table
    function automatic logic [ENT_W-1:0] entry_base(input logic [FRAME_W-1:0] frame);
        logic [31:0] prod;
        prod = 32'(frame) * 32'(SLOTS);
        return prod[ENT_W-1:0];
    endfunction

    function automatic logic [FRAME_W-1:0] frame_step(input logic [FRAME_W-1:0] frame);
        logic [FRAME_W-1:0] nxt;
        if (32'(frame) >= 32'(FRAMES - 1)) begin
            nxt = '0;
        end else begin
            nxt = frame + FRAME_W'(1);
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

@@ design/aged_keyed_slot_cache_unit.sv @@
`default_nettype none
// Keyed slot cache with age-based eviction, one slot table per frame.
// Input stream (s_*): s_tuser selects the request, s_tdata carries the key.
//   Lookup: hit reports the slot; a miss claims the lowest free slot of the
//   current frame (age 0) or reports full. Tick: advance the frame, age the
//   valid slots of the new frame and evict those older than max_age.
// Output stream (m_*): one transaction per request, status on m_tuser,
//   slot and current frame on m_tdata.
// Config channel (cfg_*): writes max_age, always ready; write only when idle.
// Every request walks the whole frame table, one entry per cycle through the key
//   or age memory read port; results are taken in the cycle after the walk.
//   s_tready returns only once the result has moved to the output register.
// Reset: all slots invalid, frame 0, max_age 8; memories are not cleared,
//   the valid flops mask them.
// Stall: a finished result sits in the output register while the next
//   request is accepted and walked; only if a second result is ready before
//   the first is taken does the block hold it and keep s_tready low.
module aged_keyed_slot_cache_unit
    import aksc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [KEY_W-1:0]     s_tdata,    // [63:0] key
    input  wire logic [0:0]           s_tuser,    // [0] action
    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,    // [5:0] slot, [6] frame_now, [7] zero
    output logic [1:0]                m_tuser,    // [1:0] status
    // config write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [MAXAGE_W-1:0]  cfg_data    // [3:0] max_age
);

    // memories: key and age per entry
    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [AGE_W-1:0] age_mem [ENTRIES];

    state_t                state_reg, state_next;
    logic [ENTRIES-1:0]    valid_reg;
    logic [FRAME_W-1:0]    frame_reg;
    logic [MAXAGE_W-1:0]   max_age_reg;
    logic                  tick_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [ENT_W-1:0]      base_reg;
    logic [SLOT_W-1:0]     cnt_reg;

    // read pipeline stage
    logic                  pend_reg;
    logic [ENT_W-1:0]      pend_addr_reg;
    logic [SLOT_W-1:0]     pend_idx_reg;
    logic [KEY_W-1:0]      key_rd_reg;
    logic [AGE_W-1:0]      age_rd_reg;

    // search results
    logic                  hit_reg;
    logic [SLOT_W-1:0]     hit_idx_reg;
    logic                  free_reg;
    logic [SLOT_W-1:0]     free_idx_reg;

    status_t               res_status_reg;
    logic [OUT_SLOT_W-1:0] res_slot_reg;
    logic [FRAME_W-1:0]    res_frame_reg;

    logic                  m_tvalid_reg;
    logic [1:0]            m_tuser_reg;
    logic [OUT_SLOT_W-1:0] m_slot_reg;
    logic                  m_frame_reg;

    logic                  s_accept;
    logic [ENT_W-1:0]      rd_addr;
    logic                  last_issue;
    logic                  key_match;
    logic                  hit_final;
    logic [SLOT_W-1:0]     hit_slot;
    logic [AGE_W-1:0]      age_inc;
    logic                  evict;
    logic                  age_we;
    logic                  alloc_we;
    logic [ENT_W-1:0]      alloc_addr;
    logic                  out_load;
    logic [FRAME_W-1:0]    frame_nxt;
    logic [31:0]           slot_wide;
    status_t               status_sel;
    logic [SLOT_W-1:0]     slot_sel;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign rd_addr    = base_reg + ENT_W'(cnt_reg);
    assign last_issue = (cnt_reg == SLOT_W'(SLOTS - 1));
    assign frame_nxt  = frame_step(frame_reg);

    // lookup compare on the entry read last cycle
    assign key_match = pend_reg && !tick_reg && valid_reg[pend_addr_reg]
                       && (key_rd_reg == key_reg);
    assign hit_final = hit_reg || key_match;
    assign hit_slot  = hit_reg ? hit_idx_reg : pend_idx_reg;

    // tick: saturating age bump, evict past max_age
    assign age_inc = (age_rd_reg < AGE_LIMIT) ? (age_rd_reg + AGE_W'(1)) : age_rd_reg;
    assign evict   = (age_inc > AGE_W'(max_age_reg));
    assign age_we  = pend_reg && tick_reg && valid_reg[pend_addr_reg];

    assign alloc_we   = (state_reg == S_LAST) && !tick_reg && !hit_final && free_reg;
    assign alloc_addr = base_reg + ENT_W'(free_idx_reg);

    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        status_sel = STAT_TICK;
        slot_sel   = '0;
        if (!tick_reg) begin
            if (hit_final) begin
                status_sel = STAT_HIT;
                slot_sel   = hit_slot;
            end else if (free_reg) begin
                status_sel = STAT_ALLOC;
                slot_sel   = free_idx_reg;
            end else begin
                status_sel = STAT_FULL;
            end
        end
    end

    assign slot_wide = 32'(slot_sel);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) state_next = S_WALK;
            end
            S_WALK: begin
                if (last_issue) state_next = S_LAST;
            end
            S_LAST: state_next = S_OUT;
            S_OUT: begin
                if (out_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            frame_reg    <= '0;
            max_age_reg  <= MAX_AGE_RESET;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) max_age_reg <= cfg_data;
            if (s_accept && (s_tuser[0] == ACT_TICK)) frame_reg <= frame_nxt;
            pend_reg <= (state_reg == S_WALK);
            if (alloc_we) begin
                valid_reg[alloc_addr] <= 1'b1;
            end else if (age_we && evict) begin
                valid_reg[pend_addr_reg] <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tick_reg <= s_tuser[0];
            key_reg  <= s_tdata;
            base_reg <= entry_base((s_tuser[0] == ACT_TICK) ? frame_nxt : frame_reg);
            cnt_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        if (state_reg == S_WALK) begin
            cnt_reg       <= cnt_reg + SLOT_W'(1);
            pend_addr_reg <= rd_addr;
            pend_idx_reg  <= cnt_reg;
            // lowest free slot, known from the valid flops at issue
            if (!tick_reg && !free_reg && !valid_reg[rd_addr]) begin
                free_reg     <= 1'b1;
                free_idx_reg <= cnt_reg;
            end
        end
        if (key_match && !hit_reg) begin
            hit_reg     <= 1'b1;
            hit_idx_reg <= pend_idx_reg;
        end
        if (state_reg == S_LAST) begin
            res_status_reg <= status_sel;
            res_slot_reg   <= slot_wide[OUT_SLOT_W-1:0];
            res_frame_reg  <= frame_reg;
        end
        if (out_load) begin
            m_tuser_reg <= res_status_reg;
            m_slot_reg  <= res_slot_reg;
            m_frame_reg <= res_frame_reg[0];
        end
    end

    // memory ports: one read, one write per cycle each
    always_ff @(posedge aclk) begin
        if (state_reg == S_WALK) begin
            key_rd_reg <= key_mem[rd_addr];
            age_rd_reg <= age_mem[rd_addr];
        end
        if (alloc_we) begin
            key_mem[alloc_addr] <= key_reg;
        end
        if (age_we) begin
            age_mem[pend_addr_reg] <= age_inc;
        end else if (alloc_we) begin
            age_mem[alloc_addr] <= '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = {1'b0, m_frame_reg, m_slot_reg};

    // assertions
    a_alloc_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        alloc_we |=> valid_reg[$past(alloc_addr)])
        else $error("allocated entry not marked valid");

    a_evict_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (age_we && evict) |=> !valid_reg[$past(pend_addr_reg)])
        else $error("aged-out entry still valid");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !pend_reg)
        else $error("read pending while idle");

    a_tick_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STAT_TICK || m_tuser == STAT_FULL)) |-> (m_tdata[5:0] == '0))
        else $error("nonzero slot on tick or full");

    a_walk_window: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == S_LAST) |-> $past(last_issue))
        else $error("walk ended early");

endmodule

`default_nettype wire

@@ tb/slot_cache_checker.sv @@
`default_nettype none

// Watches the request, result and max_age channels, keeps its own copy of
// the per-frame slot tables and checks every result transaction in order.
module slot_cache_checker
    import aksc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [KEY_W-1:0]     s_tdata,    // [63:0] key
    input  wire logic [0:0]           s_tuser,    // [0] action
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [7:0]           m_tdata,    // [5:0] slot, [6] frame_now, [7] zero
    input  wire logic [1:0]           m_tuser,    // [1:0] status
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [MAXAGE_W-1:0]  cfg_data,   // [3:0] max_age
    output int                        mismatches,
    output int                        replies_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t                 status;
        logic [OUT_SLOT_W-1:0]   slot;
        logic                    frame_now;
    } cache_reply_t;

    cache_reply_t          expected_replies[$];

    logic                  tbl_valid [FRAMES][SLOTS];
    logic [KEY_W-1:0]      tbl_key   [FRAMES][SLOTS];
    logic [AGE_W-1:0]      tbl_age   [FRAMES][SLOTS];
    int unsigned           cur_frame;
    logic [MAXAGE_W-1:0]   evict_after;

    initial begin
        mismatches      = 0;
        replies_pending = 0;
    end

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        $display("mismatch at %0t ns: %s expected %0h got %0h", $time, what, want, got);
    endtask

    // Applies one request to the shadow tables and returns the reply it earns.
    function automatic cache_reply_t resolve_request(logic action, logic [KEY_W-1:0] req_key);
        cache_reply_t reply;
        bit           found;
        reply.status    = STAT_FULL;
        reply.slot      = '0;
        found           = 1'b0;
        if (action == ACT_TICK) begin
            cur_frame = (cur_frame == FRAMES - 1) ? 0 : cur_frame + 1;
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_valid[cur_frame][i]) begin
                    if (tbl_age[cur_frame][i] < AGE_LIMIT) begin
                        tbl_age[cur_frame][i] = tbl_age[cur_frame][i] + 1'b1;
                    end
                    if (tbl_age[cur_frame][i] > evict_after) begin
                        tbl_valid[cur_frame][i] = 1'b0;
                    end
                end
            end
            reply.status = STAT_TICK;
        end else begin
            // hit leaves the age alone
            for (int i = 0; i < SLOTS; i++) begin
                if (!found && tbl_valid[cur_frame][i] && tbl_key[cur_frame][i] == req_key) begin
                    found        = 1'b1;
                    reply.status = STAT_HIT;
                    reply.slot   = OUT_SLOT_W'(i);
                end
            end
            // miss: lowest free slot wins
            for (int i = 0; i < SLOTS; i++) begin
                if (!found && !tbl_valid[cur_frame][i]) begin
                    found                   = 1'b1;
                    tbl_valid[cur_frame][i] = 1'b1;
                    tbl_key[cur_frame][i]   = req_key;
                    tbl_age[cur_frame][i]   = '0;
                    reply.status            = STAT_ALLOC;
                    reply.slot              = OUT_SLOT_W'(i);
                end
            end
        end
        reply.frame_now = cur_frame[0];
        return reply;
    endfunction

    always @(posedge aclk) begin
        cache_reply_t want;
        if (!aresetn) begin
            foreach (tbl_valid[f, i]) begin
                tbl_valid[f][i] = 1'b0;
                tbl_key[f][i]   = '0;
                tbl_age[f][i]   = '0;
            end
            cur_frame   = 0;
            evict_after = MAX_AGE_RESET;
            expected_replies.delete();
        end else begin
            // retire before accepting so a same-edge request never matches itself
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected result, status/tdata", m_tuser, m_tdata);
                end else begin
                    want = expected_replies.pop_front();
                    if (m_tuser != want.status) begin
                        report_mismatch("status", want.status, m_tuser);
                    end
                    if (m_tdata[5:0] != want.slot) begin
                        report_mismatch("slot", want.slot, m_tdata[5:0]);
                    end
                    if (m_tdata[6] != want.frame_now) begin
                        report_mismatch("frame_now", want.frame_now, m_tdata[6]);
                    end
                    if (m_tdata[7] != 1'b0) begin
                        report_mismatch("tdata pad bit", 0, m_tdata[7]);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                evict_after = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(resolve_request(s_tuser[0], s_tdata));
            end
        end
        replies_pending <= expected_replies.size();
    end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

// Stimulus and verdict for the aged keyed slot cache. All prediction and
// checking lives in slot_cache_checker; this module only drives the
// channels and decides pass/fail from the checker's mismatch count.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aksc_pkg::*;

    // ~600 transactions plus worst-case gaps and stalls stay well under the
    // limit; it leaves ample headroom.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // one full table walk plus output register, with margin
    localparam int SETTLE_CYCLES = 150;
    // long enough for two results to pile up and s_tready to drop
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_ITEMS   = 60;
    localparam int POOL_DEPTH    = 96;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [KEY_W-1:0]     s_tdata   = '0;   // [63:0] key
    logic [0:0]           s_tuser   = '0;   // [0] action
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // [5:0] slot, [6] frame_now, [7] zero
    logic [1:0]           m_tuser;          // [1:0] status
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [MAXAGE_W-1:0]  cfg_data  = '0;   // [3:0] max_age

    int                   mismatches;
    int                   replies_pending;
    int                   cycle_count = 0;

    // Recently used keys; drawing from here is what makes hits happen.
    logic [KEY_W-1:0]     key_pool[$];
    bit                   sender_gaps  = 1'b1;
    bit                   hold_results = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    aged_keyed_slot_cache_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    slot_cache_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .replies_pending (replies_pending)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("testbench failed");
        $finish;
    end

    // Result side backpressure. Mostly ready, short random stalls, the odd
    // longer one, and on request a long hold that lets the block fill up.
    initial begin
        int pick;
        forever begin
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, 30)) @(posedge aclk);
                end else if (pick < 90) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else if (pick < 97) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge aclk);
                end else begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(100, 200)) @(posedge aclk);
                end
            end
        end
    end

    // Sender idle time after a transaction: mostly none, sometimes a few
    // cycles, rarely a long pause. valid only drops when a gap is taken.
    task automatic sender_pause();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        gap  = 0;
        if (sender_gaps) begin
            if (pick >= 90) begin
                gap = $urandom_range(20, 120);
            end else if (pick >= 60) begin
                gap = $urandom_range(1, 4);
            end
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // One request transaction; returns once it has been accepted.
    task automatic offer(logic action, logic [KEY_W-1:0] key);
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        sender_pause();
    endtask

    task automatic lookup(logic [KEY_W-1:0] key);
        offer(ACT_LOOKUP, key);
    endtask

    // key is don't-care on a tick, so feed it garbage
    task automatic tick();
        offer(ACT_TICK, {$urandom, $urandom});
    endtask

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] key;
        key = {$urandom, $urandom};
        key_pool.push_back(key);
        if (key_pool.size() > POOL_DEPTH) begin
            void'(key_pool.pop_front());
        end
        return key;
    endfunction

    function automatic logic [KEY_W-1:0] pooled_key();
        if (key_pool.size() == 0) begin
            return fresh_key();
        end
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    // Stop offering and wait for every outstanding result to come back.
    // The extra edge lets the checker's count catch the last transaction.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_pending != 0) @(posedge aclk);
    endtask

    // max_age is only changed with the block idle.
    task automatic set_max_age(logic [MAXAGE_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Misses in a row with no tick: past 64 the current frame is full.
    task automatic fill_frame(int count);
        repeat (count) lookup(fresh_key());
    endtask

    // Random part. Work comes in bursts: table fills, runs of ticks to push
    // ages toward eviction, mixed lookups biased toward known keys, and a
    // little pure noise.
    task automatic run_mix(int items);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                len = $urandom_range(20, 72);
                fill_frame(len);
            end else if (pick < 4) begin
                len = $urandom_range(1, 6);
                repeat (len) tick();
            end else if (pick < 9) begin
                len = $urandom_range(5, 20);
                repeat (len) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 15) begin
                        tick();
                    end else if (pick < 70) begin
                        lookup(pooled_key());
                    end else begin
                        lookup(fresh_key());
                    end
                end
            end else begin
                len = $urandom_range(1, 5);
                repeat (len) offer(1'($urandom_range(0, 1)), {$urandom, $urandom});
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme keys, hit/alloc in both frames, tick ignoring
        // its key, and hits on entries that have been aged.
        lookup('0);
        lookup('1);
        lookup('0);
        lookup('1);
        lookup({32{2'b10}});
        lookup({32{2'b01}});
        offer(ACT_TICK, '1);
        lookup('0);
        lookup({1'b1, 63'b0});
        lookup(64'd1);
        offer(ACT_TICK, '0);
        lookup('1);
        lookup('0);
        tick();
        lookup({32{2'b01}});
        lookup(64'd1);
        tick();
        lookup({32{2'b10}});
        lookup({32{2'b01}});

        // Longest lifetime: fill a frame past full, then mixed traffic.
        set_max_age(4'd15);
        fill_frame(70);
        run_mix(PHASE_ITEMS);

        // Quick eviction, with the result side held off long enough that
        // the block backs up into s_tready.
        set_max_age(4'd1);
        hold_results = 1'b1;
        run_mix(PHASE_ITEMS);

        // Zero: every valid slot of the new frame goes on each tick.
        set_max_age(4'd0);
        sender_gaps = 1'b0;
        run_mix(PHASE_ITEMS);
        sender_gaps = 1'b1;

        set_max_age(4'd8);
        run_mix(PHASE_ITEMS);

        set_max_age(4'($urandom_range(1, 15)));
        sender_gaps = 1'($urandom_range(0, 1));
        run_mix(PHASE_ITEMS);
        sender_gaps = 1'b1;

        set_max_age(4'd2);
        fill_frame(66);
        run_mix(PHASE_ITEMS);

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
